>>> rtl/int2rom_pkg.sv
package int2rom_pkg;

   localparam int VALUE_W = 14;
   localparam int CHAR_W  = 7;
   localparam int DIGIT_W = 4;
   localparam int SCALE_W = 2;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

   // decimal places, most significant first
   localparam logic [SCALE_W-1:0] SCALE_THOUSANDS = 2'd0;
   localparam logic [SCALE_W-1:0] SCALE_HUNDREDS  = 2'd1;
   localparam logic [SCALE_W-1:0] SCALE_TENS      = 2'd2;
   localparam logic [SCALE_W-1:0] SCALE_ONES      = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_M  = 7'h4D;
   localparam logic [CHAR_W-1:0] CHAR_D  = 7'h44;
   localparam logic [CHAR_W-1:0] CHAR_C  = 7'h43;
   localparam logic [CHAR_W-1:0] CHAR_L  = 7'h4C;
   localparam logic [CHAR_W-1:0] CHAR_X  = 7'h58;
   localparam logic [CHAR_W-1:0] CHAR_V  = 7'h56;
   localparam logic [CHAR_W-1:0] CHAR_I  = 7'h49;
   localparam logic [CHAR_W-1:0] CHAR_NL = 7'h0A;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [DIGIT_W-1:0] pos;
      logic [SCALE_W-1:0] scale;
   } query_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] len;
      logic [CHAR_W-1:0]  char_code;
   } glyph_type;

   function automatic logic [VALUE_W-1:0] scale_weight(input logic [SCALE_W-1:0] scale);
      logic [VALUE_W-1:0] w;
      case (scale)
         SCALE_THOUSANDS: w = 14'd1000;
         SCALE_HUNDREDS:  w = 14'd100;
         SCALE_TENS:      w = 14'd10;
         default:         w = 14'd1;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/int2rom_if.sv
interface int2rom_req_if;
   logic                               valid;
   logic                               ready;
   logic [int2rom_pkg::VALUE_W-1:0]    value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface int2rom_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [int2rom_pkg::CHAR_W-1:0]     char_code;
   logic                               last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/integer_to_roman_numeral_top.sv
// From the accepted word until the newline word is registered, one shared
// subtract-and-compare unit peels the thousands, hundreds and tens digits off by
// repeated subtraction, the ones digit is taken from the remainder, and each digit's
// characters leave one per cycle while the output is not stalled. Words are taken one
// at a time; the next input is taken in the idle cycle after the newline is registered.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
module integer_to_roman_numeral_top (
   input  logic                 clock,
   input  logic                 reset,
   int2rom_req_if.sink          req_ch,
   int2rom_rsp_if.source        rsp_ch
);
   import int2rom_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_NL   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [DIGIT_W-1:0]  digit_ff, digit_in;
   logic [DIGIT_W-1:0]  pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0]  weight;
   logic [VALUE_W:0]    diff;
   logic                fits;
   logic                slot_free;
   query_type           query;
   glyph_type           glyph;

   // shared unit: one subtract, the borrow doubles as the compare
   assign weight = scale_weight(scale_ff);
   assign diff   = {1'b0, rem_ff} - {1'b0, weight};
   assign fits   = ~diff[VALUE_W];

   assign query.digit = digit_ff;
   assign query.pos   = pos_ff;
   assign query.scale = scale_ff;

   int2rom_glyph u_glyph (
      .query (query),
      .glyph (glyph)
   );

   assign slot_free    = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      scale_in     = scale_ff;
      digit_in     = digit_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               rem_in   = (req_ch.value > VALUE_MAX) ? VALUE_MAX : req_ch.value;
               scale_in = SCALE_THOUSANDS;
               digit_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (scale_ff == SCALE_ONES) begin
               digit_in = rem_ff[DIGIT_W-1:0];
               pos_in   = '0;
               state_in = ST_EMIT;
            end else if (fits) begin
               rem_in   = diff[VALUE_W-1:0];
               digit_in = digit_ff + 4'd1;
            end else begin
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (pos_ff == glyph.len) begin
               if (scale_ff == SCALE_ONES) begin
                  state_in = ST_NL;
               end else begin
                  scale_in = scale_ff + 2'd1;
                  digit_in = '0;
                  state_in = ST_DIV;
               end
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = glyph.char_code;
               rsp_last_in  = 1'b0;
               pos_in       = pos_ff + 4'd1;
            end
         end
         ST_NL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_NL;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      scale_ff    <= scale_in;
      digit_ff    <= digit_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.char_code = rsp_char_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

>>> rtl/int2rom_glyph.sv
module int2rom_glyph (
   input  int2rom_pkg::query_type query,
   output int2rom_pkg::glyph_type glyph
);
   import int2rom_pkg::*;

   logic [CHAR_W-1:0] unit_ch;
   logic [CHAR_W-1:0] five_ch;
   logic [CHAR_W-1:0] ten_ch;

   always_comb begin
      case (query.scale)
         SCALE_THOUSANDS: begin
            unit_ch = CHAR_M;
            five_ch = CHAR_M;
            ten_ch  = CHAR_M;
         end
         SCALE_HUNDREDS: begin
            unit_ch = CHAR_C;
            five_ch = CHAR_D;
            ten_ch  = CHAR_M;
         end
         SCALE_TENS: begin
            unit_ch = CHAR_X;
            five_ch = CHAR_L;
            ten_ch  = CHAR_C;
         end
         default: begin
            unit_ch = CHAR_I;
            five_ch = CHAR_V;
            ten_ch  = CHAR_X;
         end
      endcase
   end

   // thousands are plain repeated M, the rest use the subtractive patterns
   always_comb begin
      if (query.scale == SCALE_THOUSANDS) begin
         glyph.len = query.digit;
      end else begin
         case (query.digit) inside
            4'd0:          glyph.len = 4'd0;
            [4'd1:4'd3]:   glyph.len = query.digit;
            4'd4, 4'd9:    glyph.len = 4'd2;
            [4'd5:4'd8]:   glyph.len = query.digit - 4'd4;
            default:       glyph.len = 4'd0;
         endcase
      end

      case (query.digit) inside
         4'd9:        glyph.char_code = (query.pos == 4'd0) ? unit_ch : ten_ch;
         4'd4:        glyph.char_code = (query.pos == 4'd0) ? unit_ch : five_ch;
         [4'd5:4'd8]: glyph.char_code = (query.pos == 4'd0) ? five_ch : unit_ch;
         default:     glyph.char_code = unit_ch;
      endcase
   end

endmodule

>>> tb/integer_to_roman_numeral_top_tb.sv
`timescale 1ns / 100ps

module integer_to_roman_numeral_top_tb;
   import int2rom_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } numeral_char_type;

   localparam int RANDOM_PER_PHASE = 26;
   localparam int SETTLE_CYCLES    = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int2rom_req_if req_ch ();
   int2rom_rsp_if rsp_ch ();

   integer_to_roman_numeral_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   numeral_char_type numeral_q[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               error_count   = 0;
   int               values_sent   = 0;
   int               saturated     = 0;
   int               chars_checked = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void push_char(input logic [CHAR_W-1:0] code, input logic is_last);
      numeral_char_type c;
      c.char_code = code;
      c.last      = is_last;
      numeral_q.push_back(c);
   endfunction

   function automatic void push_digit(input int digit, input logic [CHAR_W-1:0] unit_ch,
                                      input logic [CHAR_W-1:0] five_ch,
                                      input logic [CHAR_W-1:0] ten_ch);
      int k;
      case (digit)
         9: begin
            push_char(unit_ch, 1'b0);
            push_char(ten_ch, 1'b0);
         end
         4: begin
            push_char(unit_ch, 1'b0);
            push_char(five_ch, 1'b0);
         end
         5, 6, 7, 8: begin
            push_char(five_ch, 1'b0);
            for (k = 5; k < digit; k++) push_char(unit_ch, 1'b0);
         end
         1, 2, 3: begin
            for (k = 0; k < digit; k++) push_char(unit_ch, 1'b0);
         end
         default: ;
      endcase
   endfunction

   // Queue every character of the numeral, newline last
   function automatic void predict_numeral(input logic [VALUE_W-1:0] value);
      int v;
      if (value > VALUE_MAX) begin
         v = int'(VALUE_MAX);
         saturated++;
      end else begin
         v = int'(value);
      end
      repeat (v / 1000) push_char(CHAR_M, 1'b0);
      push_digit((v / 100) % 10, CHAR_C, CHAR_D, CHAR_M);
      push_digit((v / 10) % 10, CHAR_X, CHAR_L, CHAR_C);
      push_digit(v % 10, CHAR_I, CHAR_V, CHAR_X);
      push_char(CHAR_NL, 1'b1);
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10)
         return VALUE_W'($urandom_range(16383, 10000));
      else if (pick < 25)
         return VALUE_W'($urandom_range(99));
      else
         return VALUE_W'($urandom_range(9) * 1000 + $urandom_range(9) * 100 +
                         $urandom_range(9) * 10 + $urandom_range(9));
   endfunction

   // Valid stays high between back-to-back words; drop it only to idle
   task automatic send_value(input logic [VALUE_W-1:0] value);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_numeral(value);
      values_sent++;
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      while (numeral_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_digit_patterns();
      int unsigned patterns[$] = '{0, 1, 4, 5, 9, 14, 40, 90, 400, 900, 1994, 3999,
                                   4444, 8888, 9888, 9999, 2468, 5461, 7000};
      foreach (patterns[i]) send_value(VALUE_W'(patterns[i]));
   endtask

   task automatic test_out_of_range();
      int unsigned patterns[$] = '{10000, 10922, 12345, 16383};
      foreach (patterns[i]) send_value(VALUE_W'(patterns[i]));
   endtask

   task automatic test_random_values(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RANDOM_PER_PHASE) send_value(random_value());
   endtask

   always @(posedge clock) begin : check_numeral_words
      numeral_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (numeral_q.size() == 0) begin
            $error("unexpected word: char_code %h, last %b", rsp_ch.char_code, rsp_ch.last);
            error_count++;
         end else begin
            want = numeral_q.pop_front();
            if (rsp_ch.char_code !== want.char_code) begin
               $error("char_code: expected %h, actual %h", want.char_code, rsp_ch.char_code);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_ch.last);
               error_count++;
            end
            chars_checked++;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 80;
      test_digit_patterns();
      test_out_of_range();
      hold_until_drained();
      test_random_values(15, 80);
      hold_until_drained();
      test_random_values(80, 15);
      hold_until_drained();
      test_random_values(0, 0);

      req_ch.valid <= 1'b0;
      while (numeral_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d above range), checked %0d numeral characters",
               values_sent, saturated, chars_checked);
      $display("Covered digit patterns, saturation and three sender/receiver stall mixes");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
